// File: rtl/plgd_pkg.sv
// ----------------------------------------------------------------------------
// plgd_pkg
// Shared constants, codes and types of the PWM channel limit guard.
// ----------------------------------------------------------------------------
package plgd_pkg;

    localparam int CHANNELS   = 16;
    localparam int CHAN_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TYPE_W     = 4;
    localparam int CH_FIELD_W = 8;
    localparam int DUTY_W     = 14;
    localparam int STATUS_W   = 3;
    localparam int ACTIVE_W   = 5;

    localparam logic [DUTY_W-1:0]     FULL_SCALE     = DUTY_W'(10000);
    localparam logic [CH_FIELD_W-1:0] CHANNELS_LIMIT = CH_FIELD_W'(CHANNELS);
    localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET   = ACTIVE_W'(16);

    typedef enum logic [TYPE_W-1:0] {
        OP_INIT       = 4'd0,
        OP_SET_DUTY   = 4'd1,
        OP_GET_DUTY   = 4'd2,
        OP_SET_ENABLE = 4'd3,
        OP_GET_ENABLE = 4'd4,
        OP_SET_LIMITS = 4'd5,
        OP_SAFE       = 4'd6,
        OP_SET_FAULT  = 4'd7,
        OP_GET_LIMITS = 4'd8
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOT_INIT = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_FAULT    = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [DUTY_W-1:0] min_duty;
        logic [DUTY_W-1:0] max_duty;
        logic [DUTY_W-1:0] safe_duty;
        logic              enable;
        logic              fault;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        duty:      '0,
        min_duty:  '0,
        max_duty:  FULL_SCALE,
        safe_duty: '0,
        enable:    1'b0,
        fault:     1'b0
    };

    typedef struct packed {
        op_t                   op;
        logic [CH_FIELD_W-1:0] channel;
        logic [DUTY_W-1:0]     duty_value;
        logic                  flag_value;
        logic [DUTY_W-1:0]     limit_min;
        logic [DUTY_W-1:0]     limit_max;
        logic [DUTY_W-1:0]     limit_safe;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [DUTY_W-1:0] read_duty;
        logic              read_enabled;
        logic [DUTY_W-1:0] read_min;
        logic [DUTY_W-1:0] read_max;
        logic [DUTY_W-1:0] read_safe;
    } rsp_t;

    typedef struct packed {
        logic   wr_en;
        entry_t entry;
        rsp_t   rsp;
    } alu_out_t;

endpackage

// File: rtl/plgd_if.sv
// ----------------------------------------------------------------------------
// plgd_if
// Valid/ready channels of the PWM channel limit guard: request, response and
// configuration write.
// ----------------------------------------------------------------------------
interface plgd_req_if;
    logic                            valid;
    logic                            ready;
    logic [plgd_pkg::TYPE_W-1:0]     req_type;
    logic [plgd_pkg::CH_FIELD_W-1:0] channel;
    logic [plgd_pkg::DUTY_W-1:0]     duty_value;
    logic                            flag_value;
    logic [plgd_pkg::DUTY_W-1:0]     limit_min;
    logic [plgd_pkg::DUTY_W-1:0]     limit_max;
    logic [plgd_pkg::DUTY_W-1:0]     limit_safe;

    modport source (output valid, req_type, channel, duty_value, flag_value,
                    limit_min, limit_max, limit_safe, input ready);
    modport sink   (input valid, req_type, channel, duty_value, flag_value,
                    limit_min, limit_max, limit_safe, output ready);
endinterface

interface plgd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [plgd_pkg::STATUS_W-1:0] status;
    logic [plgd_pkg::DUTY_W-1:0]   read_duty;
    logic                          read_enabled;
    logic [plgd_pkg::DUTY_W-1:0]   read_min;
    logic [plgd_pkg::DUTY_W-1:0]   read_max;
    logic [plgd_pkg::DUTY_W-1:0]   read_safe;

    modport source (output valid, status, read_duty, read_enabled, read_min,
                    read_max, read_safe, input ready);
    modport sink   (input valid, status, read_duty, read_enabled, read_min,
                    read_max, read_safe, output ready);
endinterface

interface plgd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [plgd_pkg::ACTIVE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/plgd_store.sv
// ----------------------------------------------------------------------------
// plgd_store
// Channel entry memory: one synchronous read port, one write port, and a
// valid bit per entry so that unwritten entries read as their reset value.
// ----------------------------------------------------------------------------
module plgd_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [plgd_pkg::CHAN_W-1:0]   rd_addr,
    input  logic                          wr_en,
    input  logic [plgd_pkg::CHAN_W-1:0]   wr_addr,
    input  plgd_pkg::entry_t              wr_data,
    output plgd_pkg::entry_t              rd_data
);

    plgd_pkg::entry_t                     mem [plgd_pkg::CHANNELS];
    plgd_pkg::entry_t                     rd_raw_reg;
    logic [plgd_pkg::CHANNELS-1:0]        valid_reg;
    logic [plgd_pkg::CHANNELS-1:0]        valid_next;
    logic                                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : plgd_pkg::ENTRY_RESET;

endmodule

// File: rtl/plgd_alu.sv
// ----------------------------------------------------------------------------
// plgd_alu
// Access evaluation: checks, clamps and limit validation on one channel entry;
// produces the updated entry and the response.
// ----------------------------------------------------------------------------
module plgd_alu (
    input  plgd_pkg::req_t     req,
    input  plgd_pkg::entry_t   cur,
    input  logic               ready_flag,
    input  logic               exists,
    output plgd_pkg::alu_out_t res
);

    function automatic logic [plgd_pkg::DUTY_W-1:0] clamp_into(
        input logic [plgd_pkg::DUTY_W-1:0] v,
        input logic [plgd_pkg::DUTY_W-1:0] lo,
        input logic [plgd_pkg::DUTY_W-1:0] hi
    );
        logic [plgd_pkg::DUTY_W-1:0] r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    plgd_pkg::entry_t  next;
    plgd_pkg::status_t status;
    logic              known;
    logic              limits_ok;
    logic              report;

    assign known = (req.op <= plgd_pkg::OP_GET_LIMITS);

    assign limits_ok = (req.limit_max <= plgd_pkg::FULL_SCALE)
                    && (req.limit_safe <= plgd_pkg::FULL_SCALE)
                    && (req.limit_max >= req.limit_min)
                    && (req.limit_safe >= req.limit_min)
                    && (req.limit_safe <= req.limit_max);

    always_comb
    begin
        next   = cur;
        status = plgd_pkg::ST_OK;
        report = 1'b0;
        if (!known)
        begin
            status = plgd_pkg::ST_RANGE;
        end
        else if (req.op == plgd_pkg::OP_INIT)
        begin
            status = plgd_pkg::ST_OK;
        end
        else if (req.op != plgd_pkg::OP_SET_FAULT && !ready_flag)
        begin
            status = plgd_pkg::ST_NOT_INIT;
        end
        else if (!exists)
        begin
            status = plgd_pkg::ST_UNKNOWN;
        end
        else
        begin
            unique case (req.op)
                plgd_pkg::OP_SET_DUTY:
                begin
                    if (cur.fault)
                    begin
                        status = plgd_pkg::ST_FAULT;
                    end
                    else
                    begin
                        next.duty = clamp_into(req.duty_value, cur.min_duty, cur.max_duty);
                    end
                end
                plgd_pkg::OP_SET_ENABLE:
                begin
                    if (cur.fault && req.flag_value)
                    begin
                        status = plgd_pkg::ST_FAULT;
                    end
                    else
                    begin
                        next.enable = req.flag_value;
                    end
                end
                plgd_pkg::OP_SET_LIMITS:
                begin
                    if (!limits_ok)
                    begin
                        status = plgd_pkg::ST_RANGE;
                    end
                    else
                    begin
                        next.min_duty  = req.limit_min;
                        next.max_duty  = req.limit_max;
                        next.safe_duty = req.limit_safe;
                        next.duty      = clamp_into(cur.duty, req.limit_min, req.limit_max);
                    end
                end
                plgd_pkg::OP_SAFE:
                begin
                    next.duty   = cur.safe_duty;
                    next.enable = 1'b0;
                end
                plgd_pkg::OP_SET_FAULT:
                begin
                    next.fault = req.flag_value;
                    if (req.flag_value)
                    begin
                        next.enable = 1'b0;
                    end
                end
                default:
                begin
                    next = cur;
                end
            endcase
            report = (status == plgd_pkg::ST_OK);
        end
    end

    always_comb
    begin
        res.wr_en            = report;
        res.entry            = next;
        res.rsp.status       = status;
        res.rsp.read_duty    = report ? next.duty : '0;
        res.rsp.read_enabled = report ? next.enable : 1'b0;
        res.rsp.read_min     = report ? next.min_duty : '0;
        res.rsp.read_max     = report ? next.max_duty : '0;
        res.rsp.read_safe    = report ? next.safe_duty : '0;
    end

endmodule

// File: rtl/pwm_channel_limit_guard.sv
// ----------------------------------------------------------------------------
// pwm_channel_limit_guard
// Multi-channel PWM duty register bank with min/max/safe limits, enable and
// fault per channel, held in a channel entry memory.
//
//   channel | role   | moves
//   --------+--------+-----------------------------------------------
//   req     | sink   | one access (type, channel, duty, flag, limits)
//   rsp     | source | status and channel state after the access
//   cfg     | sink   | active_channels write
//
// Each transaction first reads the channel entry synchronously, then
// evaluates it and writes it back.
// A new request is taken once the previous one is written back; a stalled
// response waits in the output register and holds the write-back only when
// a second response is ready behind it.
// After reset every entry reads as its reset value through per-entry valid
// bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pwm_channel_limit_guard (
    input  logic       clk,
    input  logic       rst_n,
    plgd_cfg_if.sink   cfg,
    plgd_req_if.sink   req,
    plgd_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    plgd_pkg::req_t                    req_reg;
    logic [plgd_pkg::ACTIVE_W-1:0]     active_reg;
    logic                              ready_flag_reg;
    logic                              ready_flag_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    plgd_pkg::rsp_t                    out_reg;
    logic                              accept;
    logic                              commit;
    logic [plgd_pkg::CH_FIELD_W-1:0]   eff_count;
    logic                              exists;
    plgd_pkg::entry_t                  rd_entry;
    plgd_pkg::alu_out_t                alu_res;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign commit    = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    assign eff_count = (plgd_pkg::CH_FIELD_W'(active_reg) > plgd_pkg::CHANNELS_LIMIT)
                     ? plgd_pkg::CHANNELS_LIMIT
                     : plgd_pkg::CH_FIELD_W'(active_reg);
    assign exists    = (req_reg.channel < eff_count);

    plgd_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (req.channel[plgd_pkg::CHAN_W-1:0]),
        .wr_en   (commit && alu_res.wr_en),
        .wr_addr (req_reg.channel[plgd_pkg::CHAN_W-1:0]),
        .wr_data (alu_res.entry),
        .rd_data (rd_entry)
    );

    plgd_alu u_alu (
        .req        (req_reg),
        .cur        (rd_entry),
        .ready_flag (ready_flag_reg),
        .exists     (exists),
        .res        (alu_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ready_flag_next = ready_flag_reg
                          || (commit && req_reg.op == plgd_pkg::OP_INIT);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= plgd_pkg::ACTIVE_RESET;
            ready_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ready_flag_reg <= ready_flag_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                active_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.op         <= plgd_pkg::op_t'(req.req_type);
            req_reg.channel    <= req.channel;
            req_reg.duty_value <= req.duty_value;
            req_reg.flag_value <= req.flag_value;
            req_reg.limit_min  <= req.limit_min;
            req_reg.limit_max  <= req.limit_max;
            req_reg.limit_safe <= req.limit_safe;
        end
        if (commit)
        begin
            out_reg <= alu_res.rsp;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.read_duty    = out_reg.read_duty;
    assign rsp.read_enabled = out_reg.read_enabled;
    assign rsp.read_min     = out_reg.read_min;
    assign rsp.read_max     = out_reg.read_max;
    assign rsp.read_safe    = out_reg.read_safe;

`ifndef SYNTHESIS
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("write-back without a response");

    a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ready_flag_reg |=> ready_flag_reg)
        else $error("initialized flag dropped");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != plgd_pkg::ST_OK) |->
        (rsp.read_duty == '0 && rsp.read_enabled == 1'b0 && rsp.read_min == '0
         && rsp.read_max == '0 && rsp.read_safe == '0))
        else $error("error response carries channel state");

    a_duty_window: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.read_min <= rsp.read_duty && rsp.read_duty <= rsp.read_max))
        else $error("duty outside its limits");

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("second request taken before write-back");
`endif

endmodule
